// ----- hw/rtl/opdc_pkg.sv -----
// types and constants shared by the one-pedal drive curve block
package opdc_pkg;

   localparam int PEDAL_W   = 16;
   localparam int SPEED_W   = 8;
   localparam int CELL_W    = 13;
   localparam int BRAKE_W   = 16;
   localparam int WINDOW_W  = 10;
   localparam int PERCENT_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPD_ENABLE         = 3'd0,
      CSR_CURVE_MODE         = 3'd1,
      CSR_RELATION_MODE      = 3'd2,
      CSR_MAX_SPEED_KPH      = 3'd3,
      CSR_MAX_BRAKE_FRACTION = 3'd4,
      CSR_FULL_CELL_MV       = 3'd5,
      CSR_RAMP_WINDOW_MV     = 3'd6
   } csr_index_type;

   // register values after reset
   localparam logic [SPEED_W-1:0]  RST_MAX_SPEED_KPH  = 8'd100;
   localparam logic [BRAKE_W-1:0]  RST_MAX_BRAKE      = 16'd0;
   localparam logic [CELL_W-1:0]   RST_FULL_CELL_MV   = 13'd4200;
   localparam logic [WINDOW_W-1:0] RST_RAMP_WINDOW_MV = 10'd50;

   // command to percent scale
   localparam logic [PERCENT_W-1:0] PCT_SCALE = 7'd100;

   typedef struct packed {
      logic [PEDAL_W-1:0] pedal_fraction;
      logic [SPEED_W-1:0] speed_kph;
      logic               brake_active;
      logic [CELL_W-1:0]  min_cell_mv;
   } opdc_req_type;

   typedef struct packed {
      logic [PEDAL_W-1:0]   drive_fraction;
      logic [PERCENT_W-1:0] drive_percent;
      logic                 regen_active;
   } opdc_rsp_type;

endpackage

// ----- hw/rtl/one_pedal_drive_curve_core.sv -----
// one-pedal drive curve: pedal and speed to drive or regen command, shared multiplier and divider
// path: with brake or one-pedal off the request goes from ST_IDLE through ST_PCT and ST_OUT to
//    the output register; otherwise the sequencer runs multiplier and divider steps first
// flow: one item at a time, held in ST_OUT on output stalls; the item steps through the restoring
//    divider (one quotient bit per cycle, DW = max(FRACTION_BITS+13, 24) bits, up to twice per item)
// reset: synchronous, active high; clears sequencer, regen flag, result valid, loads defaults
module one_pedal_drive_curve_core #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  opdc_pkg::opdc_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output opdc_pkg::opdc_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [opdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [opdc_pkg::CSR_DATA_W-1:0]   csr_data
);

   import opdc_pkg::*;

   // datapath widths, all derived from the fraction format
   localparam int FB   = FRACTION_BITS;
   localparam int CW   = FB + 1;                       // command, 0..one
   localparam int SOW  = FB + 8;                       // speed times one
   localparam int PMW  = FB + 9;                       // pedal times max speed
   localparam int TW   = FB + 8;                       // quotient that gets squared
   localparam int MAW  = FB + 16;                      // multiplier operand a
   localparam int MBW  = (FB + 8 > 16) ? FB + 8 : 16;  // multiplier operand b
   localparam int PRW  = MAW + MBW;                    // product
   localparam int DW   = (FB + 13 > 24) ? FB + 13 : 24; // dividend and quotient
   localparam int DENW = WINDOW_W;                     // divisor
   localparam int DCW  = $clog2(DW + 1);

   localparam logic [PRW-1:0] ONE_W     = PRW'(1) << FB;
   localparam logic [CW-1:0]  ONE_C     = ONE_W[CW-1:0];
   localparam logic [DCW-1:0] DIV_STEPS = DCW'(DW);

   // sequencer states
   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_PM   = 14'b00000000000010,  // pedal times max speed
      ST_PP   = 14'b00000000000100,  // that times pedal again, for the squared relation
      ST_DEC  = 14'b00000000001000,  // drive or regen decision
      ST_LMUL = 14'b00000000010000,  // numerator of a linear curve
      ST_LDIV = 14'b00000000100000,  // start the linear curve division
      ST_DIV  = 14'b00000001000000,  // divider running
      ST_SQ   = 14'b00000010000000,  // quotient squared
      ST_SQD  = 14'b00000100000000,  // drive result, or square times max brake
      ST_SQB  = 14'b00001000000000,  // quadratic regen result
      ST_RAMP = 14'b00010000000000,  // regen ramp near full cell voltage
      ST_RDIV = 14'b00100000000000,  // start the ramp division
      ST_PCT  = 14'b01000000000000,  // command times hundred
      ST_OUT  = 14'b10000000000000   // hand the result to the output register
   } state_type;

   // what the divider is working on
   typedef enum logic [2:0] {
      DK_DRV_QUAD = 3'd0,
      DK_DRV_LIN  = 3'd1,
      DK_RGN_QUAD = 3'd2,
      DK_RGN_LIN  = 3'd3,
      DK_RAMP     = 3'd4
   } div_kind_type;

   // configuration registers
   logic                opd_enable_ff, opd_enable_in;
   logic                curve_mode_ff, curve_mode_in;
   logic                relation_mode_ff, relation_mode_in;
   logic [SPEED_W-1:0]  max_speed_ff, max_speed_in;
   logic [BRAKE_W-1:0]  max_brake_ff, max_brake_in;
   logic [CELL_W-1:0]   full_cell_ff, full_cell_in;
   logic [WINDOW_W-1:0] ramp_window_ff, ramp_window_in;

   // sequencer and item registers
   state_type           state_ff, state_in;
   logic                regen_ff, regen_in;
   logic                drive_ff, drive_in;
   logic [CW-1:0]       p_ff, p_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [PMW-1:0]      pm_ff, pm_in;
   logic [CW-1:0]       cmd_ff, cmd_in;

   // shared multiplier
   logic [MAW-1:0]      mul_a;
   logic [MBW-1:0]      mul_b;
   logic                mul_en;
   logic [PRW-1:0]      mul_p;
   logic [PRW-1:0]      prod_ff, prod_in;

   // shared restoring divider
   logic [DW-1:0]       quo_ff, quo_in;
   logic [DENW-1:0]     rem_ff, rem_in;
   logic [DENW-1:0]     den_ff, den_in;
   logic [DCW-1:0]      dcnt_ff, dcnt_in;
   div_kind_type        divk_ff, divk_in;
   logic                div_go;
   logic [DW-1:0]       div_num;
   logic [DENW-1:0]     div_den;
   logic [DENW:0]       div_trial;
   logic                div_ge;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   opdc_rsp_type        rsp_data_ff, rsp_data_in;

   // derived values
   logic [SPEED_W-1:0]  mx;
   logic [SOW-1:0]      so;
   logic [PMW-1:0]      so_ext;
   logic                pm_gt_so;
   logic [PMW-1:0]      e_abs;
   logic [PRW-1:0]      so_sq;
   logic                drive_dec;
   logic [PRW-1:0]      prod_shr;
   logic [PRW-1:0]      prod_shr2;
   logic [CW-1:0]       prod_sat;
   logic [PRW-1:0]      quo_w;
   logic [CW-1:0]       quo_sat;
   logic [CW-1:0]       drv_lin;
   logic [PRW-1:0]      pedal_w;
   logic [CW-1:0]       pedal_sat;
   logic [PRW-1:0]      brake_w;
   logic [CW-1:0]       brake_sat;
   logic                cell_ge_full;
   logic                cell_in_band;
   logic [CELL_W-1:0]   full_minus_cell;
   logic [PRW-1:0]      cmd_w;

   // a zero max speed counts as one
   assign mx       = (max_speed_ff == '0) ? SPEED_W'(1) : max_speed_ff;
   assign so       = {speed_ff, {FB{1'b0}}};
   assign so_ext   = PMW'(so);
   assign pm_gt_so = pm_ff > so_ext;
   assign e_abs    = pm_gt_so ? pm_ff - so_ext : so_ext - pm_ff;
   assign so_sq    = PRW'(so) << FB;

   // pedal against speed fraction, plain or squared, exact on integers
   assign drive_dec = relation_mode_ff ? (prod_ff > so_sq) : pm_gt_so;

   // saturation to one of the various intermediate results
   assign prod_shr  = prod_ff >> FB;
   assign prod_shr2 = prod_ff >> 2;
   assign prod_sat  = (prod_shr > ONE_W) ? ONE_C : prod_shr[CW-1:0];
   assign quo_w     = PRW'(quo_ff);
   assign quo_sat   = (quo_w > ONE_W) ? ONE_C : quo_ff[CW-1:0];
   assign drv_lin   = (quo_w >= ONE_W) ? '0 : ONE_C - quo_ff[CW-1:0];
   assign pedal_w   = PRW'(req_data.pedal_fraction);
   assign pedal_sat = (pedal_w > ONE_W) ? ONE_C : pedal_w[CW-1:0];
   assign brake_w   = PRW'(max_brake_ff);
   assign brake_sat = (brake_w > ONE_W) ? ONE_C : brake_w[CW-1:0];
   assign cmd_w     = PRW'(cmd_ff);

   // ramp band: full - window <= cell < full, taken unsigned as cell + window >= full
   assign cell_ge_full    = cell_ff >= full_cell_ff;
   assign cell_in_band    = (14'(cell_ff) + 14'(ramp_window_ff)) >= 14'(full_cell_ff);
   assign full_minus_cell = full_cell_ff - cell_ff;

   // divider step: one quotient bit per cycle
   assign div_trial = {rem_ff, quo_ff[DW-1]};
   assign div_ge    = div_trial >= {1'b0, den_ff};

   // operand selection for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (state_ff)
         ST_PM: begin
            mul_a = MAW'(p_ff);
            mul_b = MBW'(mx);
         end
         ST_PP: begin
            mul_a = MAW'(prod_ff[PMW-1:0]);
            mul_b = MBW'(p_ff);
         end
         ST_LMUL: begin
            if (drive_ff) begin
               mul_a = MAW'(ONE_C - p_ff);
               mul_b = MBW'(mx);
            end else begin
               mul_a = MAW'(so_ext - pm_ff);
               mul_b = MBW'(max_brake_ff);
            end
         end
         ST_SQ: begin
            mul_a = MAW'(quo_ff[TW-1:0]);
            mul_b = MBW'(quo_ff[TW-1:0]);
         end
         ST_SQD: begin
            mul_a = prod_shr[MAW-1:0];
            mul_b = MBW'(max_brake_ff);
         end
         ST_RAMP: begin
            mul_a = MAW'(cmd_ff);
            mul_b = MBW'(full_minus_cell);
         end
         ST_PCT: begin
            mul_a = MAW'(cmd_ff);
            mul_b = MBW'(PCT_SCALE);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_en ? mul_p : prod_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      regen_in     = regen_ff;
      drive_in     = drive_ff;
      p_in         = p_ff;
      speed_in     = speed_ff;
      cell_in      = cell_ff;
      pm_in        = pm_ff;
      cmd_in       = cmd_ff;
      divk_in      = divk_ff;
      div_go       = 1'b0;
      div_num      = '0;
      div_den      = '0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      // result leaves on its transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               p_in     = pedal_sat;
               speed_in = req_data.speed_kph;
               cell_in  = req_data.min_cell_mv;
               if (req_data.brake_active || !opd_enable_ff) begin
                  // pass-through, flag left as it is
                  cmd_in   = pedal_sat;
                  state_in = ST_PCT;
               end else begin
                  state_in = ST_PM;
               end
            end
         end
         ST_PM: begin
            state_in = ST_PP;
         end
         ST_PP: begin
            pm_in    = prod_ff[PMW-1:0];
            state_in = ST_DEC;
         end
         ST_DEC: begin
            drive_in = drive_dec;
            regen_in = !drive_dec;
            if (drive_dec) begin
               if (curve_mode_ff) begin
                  div_go   = 1'b1;
                  div_num  = DW'(e_abs);
                  div_den  = DENW'(mx - speed_ff);
                  divk_in  = DK_DRV_QUAD;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_LMUL;
               end
            end else if (speed_ff == '0) begin
               // standstill gives full braking
               cmd_in   = brake_sat;
               state_in = ST_RAMP;
            end else if (curve_mode_ff) begin
               div_go   = 1'b1;
               div_num  = DW'(e_abs);
               div_den  = DENW'(speed_ff);
               divk_in  = DK_RGN_QUAD;
               state_in = ST_DIV;
            end else if (so_ext > pm_ff) begin
               state_in = ST_LMUL;
            end else begin
               cmd_in   = '0;
               state_in = ST_RAMP;
            end
         end
         ST_LMUL: begin
            state_in = ST_LDIV;
         end
         ST_LDIV: begin
            div_go = 1'b1;
            if (drive_ff) begin
               // divide by four times the speed margin
               div_num = prod_shr2[DW-1:0];
               div_den = DENW'(mx - speed_ff);
               divk_in = DK_DRV_LIN;
            end else begin
               // divide by speed times one
               div_num = prod_shr[DW-1:0];
               div_den = DENW'(speed_ff);
               divk_in = DK_RGN_LIN;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dcnt_ff == '0) begin
               unique case (divk_ff)
                  DK_DRV_QUAD, DK_RGN_QUAD: begin
                     state_in = ST_SQ;
                  end
                  DK_DRV_LIN: begin
                     cmd_in   = drv_lin;
                     state_in = ST_PCT;
                  end
                  DK_RGN_LIN: begin
                     cmd_in   = quo_sat;
                     state_in = ST_RAMP;
                  end
                  default: begin
                     cmd_in   = quo_sat;
                     state_in = ST_PCT;
                  end
               endcase
            end
         end
         ST_SQ: begin
            state_in = ST_SQD;
         end
         ST_SQD: begin
            if (drive_ff) begin
               cmd_in   = prod_sat;
               state_in = ST_PCT;
            end else begin
               state_in = ST_SQB;
            end
         end
         ST_SQB: begin
            cmd_in   = prod_sat;
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            if (cell_ge_full) begin
               cmd_in   = '0;
               state_in = ST_PCT;
            end else if (cell_in_band) begin
               state_in = ST_RDIV;
            end else begin
               state_in = ST_PCT;
            end
         end
         ST_RDIV: begin
            div_go   = 1'b1;
            div_num  = prod_ff[DW-1:0];
            div_den  = ramp_window_ff;
            divk_in  = DK_RAMP;
            state_in = ST_DIV;
         end
         ST_PCT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.drive_fraction = cmd_w[PEDAL_W-1:0];
               rsp_data_in.drive_percent  = prod_shr[PERCENT_W-1:0];
               rsp_data_in.regen_active   = regen_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // divider registers
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dcnt_in = dcnt_ff;
      if (div_go) begin
         quo_in  = div_num;
         rem_in  = '0;
         den_in  = div_den;
         dcnt_in = DIV_STEPS;
      end else if (state_ff == ST_DIV && dcnt_ff != '0) begin
         rem_in  = div_ge ? DENW'(div_trial - {1'b0, den_ff}) : div_trial[DENW-1:0];
         quo_in  = {quo_ff[DW-2:0], div_ge};
         dcnt_in = dcnt_ff - DCW'(1);
      end
   end

   // register writes, taken at any time
   always_comb begin
      opd_enable_in    = opd_enable_ff;
      curve_mode_in    = curve_mode_ff;
      relation_mode_in = relation_mode_ff;
      max_speed_in     = max_speed_ff;
      max_brake_in     = max_brake_ff;
      full_cell_in     = full_cell_ff;
      ramp_window_in   = ramp_window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OPD_ENABLE:         opd_enable_in    = csr_data[0];
            CSR_CURVE_MODE:         curve_mode_in    = csr_data[0];
            CSR_RELATION_MODE:      relation_mode_in = csr_data[0];
            CSR_MAX_SPEED_KPH:      max_speed_in     = csr_data[SPEED_W-1:0];
            CSR_MAX_BRAKE_FRACTION: max_brake_in     = csr_data[BRAKE_W-1:0];
            CSR_FULL_CELL_MV:       full_cell_in     = csr_data[CELL_W-1:0];
            CSR_RAMP_WINDOW_MV:     ramp_window_in   = csr_data[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         regen_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         dcnt_ff          <= '0;
         opd_enable_ff    <= 1'b0;
         curve_mode_ff    <= 1'b0;
         relation_mode_ff <= 1'b0;
         max_speed_ff     <= RST_MAX_SPEED_KPH;
         max_brake_ff     <= RST_MAX_BRAKE;
         full_cell_ff     <= RST_FULL_CELL_MV;
         ramp_window_ff   <= RST_RAMP_WINDOW_MV;
      end else begin
         state_ff         <= state_in;
         regen_ff         <= regen_in;
         rsp_valid_ff     <= rsp_valid_in;
         dcnt_ff          <= dcnt_in;
         opd_enable_ff    <= opd_enable_in;
         curve_mode_ff    <= curve_mode_in;
         relation_mode_ff <= relation_mode_in;
         max_speed_ff     <= max_speed_in;
         max_brake_ff     <= max_brake_in;
         full_cell_ff     <= full_cell_in;
         ramp_window_ff   <= ramp_window_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      drive_ff    <= drive_in;
      p_ff        <= p_in;
      speed_ff    <= speed_in;
      cell_ff     <= cell_in;
      pm_ff       <= pm_in;
      cmd_ff      <= cmd_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      divk_ff     <= divk_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ports
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule
